### rtl/core/epoch_day_to_calendar_date_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the day-to-date converter. They compile
// to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef EPOCH_DAY_TO_CALENDAR_DATE_ASSERT_SVH
`define EPOCH_DAY_TO_CALENDAR_DATE_ASSERT_SVH

`ifndef SYNTH
// Property holds at every clock edge outside reset.
`define EDC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Antecedent implies the consequent in the next cycle.
`define EDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define EDC_ASSERT(label, clk, rst_n, prop)
`define EDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/edc_pkg.sv
// ----------------------------------------------------------------------------
// edc_pkg
// Types, constants and the month length table of the day-to-date converter.
// ----------------------------------------------------------------------------
package edc_pkg;

  localparam int unsigned DAY_W   = 15;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DOM_W   = 5;
  localparam int unsigned YEAR_W  = 11;
  localparam int unsigned YLEN_W  = 9;

  // Covered span: 1 January FIRST_YEAR through 31 December END_YEAR - 1.
  localparam int unsigned FIRST_YEAR = 1970;
  localparam int unsigned END_YEAR   = 2030;
  localparam bit          SPAN_OK    = (END_YEAR > FIRST_YEAR);

  localparam logic [YEAR_W-1:0]  YEAR_FIRST = YEAR_W'(FIRST_YEAR);
  localparam logic [YEAR_W-1:0]  YEAR_LAST  = YEAR_W'(END_YEAR - 1);
  localparam logic [MONTH_W-1:0] MONTH_DEC  = MONTH_W'(11);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic load;
    logic year_step;
    logic month_step;
    logic mark_bad;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic res_ok;
    logic year_fits;
    logic year_last;
    logic month_fits;
    logic month_last;
    logic out_free;
  } status_t;

  function automatic logic [DOM_W-1:0] month_len(input logic [MONTH_W-1:0] idx,
                                                 input logic leap);
    logic [DOM_W-1:0] len;
    unique case (idx)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### rtl/core/edc_day_if.sv
// ----------------------------------------------------------------------------
// edc_day_if
// Valid/ready channel carrying one day number.
// ----------------------------------------------------------------------------
interface edc_day_if;
  logic                      valid;
  logic                      ready;
  logic [edc_pkg::DAY_W-1:0] day_count;

  modport source (output valid, output day_count, input ready);
  modport sink   (input valid, input day_count, output ready);
endinterface

### rtl/core/edc_date_if.sv
// ----------------------------------------------------------------------------
// edc_date_if
// Valid/ready channel carrying one calendar date result.
// ----------------------------------------------------------------------------
interface edc_date_if;
  logic                        valid;
  logic                        ready;
  logic [edc_pkg::MONTH_W-1:0] month;
  logic [edc_pkg::DOM_W-1:0]   day_of_month;
  logic [edc_pkg::YEAR_W-1:0]  year;
  logic                        valid_res;

  modport source (output valid, output month, output day_of_month, output year,
                  output valid_res, input ready);
  modport sink   (input valid, input month, input day_of_month, input year,
                  input valid_res, output ready);
endinterface

### rtl/core/epoch_day_to_calendar_date.sv
// ----------------------------------------------------------------------------
// epoch_day_to_calendar_date
// Converts a day number (1 = 1 January 1970) into month, day of month and
// year for dates from 1970 through 2029. Day zero and day numbers past
// 31 December 2029 return valid_res = 0 with all date fields zero. One
// transaction in gives one transaction out. An item is accepted, then the
// years are walked one at a time, then the months, and then the date is
// loaded into the output register. The next day number is accepted as
// soon as the previous date sits in the output register, even while that
// date still waits to be taken.
// ----------------------------------------------------------------------------
module epoch_day_to_calendar_date (
  input logic        clk_i,
  input logic        rst_ni,
  edc_day_if.sink    day_i,
  edc_date_if.source date_o
);

  edc_pkg::cmd_t    cmd;
  edc_pkg::status_t status;

  edc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (day_i.valid),
    .in_ready_o (day_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  edc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .day_count_i    (day_i.day_count),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (date_o.valid),
    .out_ready_i    (date_o.ready),
    .month_o        (date_o.month),
    .day_of_month_o (date_o.day_of_month),
    .year_o         (date_o.year),
    .valid_res_o    (date_o.valid_res)
  );

endmodule

### rtl/core/edc_ctrl.sv
// ----------------------------------------------------------------------------
// edc_ctrl
// Sequencer: accepts a day number, walks the years, then the months, then
// hands the date to the output register; a bad day number skips the months.
// ----------------------------------------------------------------------------
`include "epoch_day_to_calendar_date_assert.svh"

module edc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  edc_pkg::status_t status_i,
  output edc_pkg::cmd_t    cmd_o
);

  edc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= edc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      edc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = edc_pkg::ST_YEAR;
        end
      end
      edc_pkg::ST_YEAR: begin
        priority if (!status_i.res_ok) begin
          state_d = edc_pkg::ST_WRITE;
        end else if (status_i.year_fits) begin
          state_d = edc_pkg::ST_MONTH;
        end else if (status_i.year_last) begin
          // ran past the last covered year
          cmd_o.mark_bad = 1'b1;
          state_d        = edc_pkg::ST_WRITE;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      edc_pkg::ST_MONTH: begin
        if (status_i.month_fits || status_i.month_last) begin
          state_d = edc_pkg::ST_WRITE;
        end else begin
          cmd_o.month_step = 1'b1;
        end
      end
      edc_pkg::ST_WRITE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = edc_pkg::ST_IDLE;
        end
      end
    endcase
  end

  `EDC_ASSERT(a_load_needs_free_slot, clk_i, rst_ni, !cmd_o.out_load || status_i.out_free)
  `EDC_ASSERT_NEXT(a_accept_starts_walk, clk_i, rst_ni, in_valid_i && in_ready_o,
                   state_q == edc_pkg::ST_YEAR)
  `EDC_ASSERT(a_ready_only_when_idle, clk_i, rst_ni,
              !in_ready_o || (state_q == edc_pkg::ST_IDLE))

endmodule

### rtl/core/edc_dp.sv
// ----------------------------------------------------------------------------
// edc_dp
// Datapath: remaining-day counter, year and month counters, and the output
// register that holds a finished date until it is taken.
// ----------------------------------------------------------------------------
`include "epoch_day_to_calendar_date_assert.svh"

module edc_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [edc_pkg::DAY_W-1:0]   day_count_i,
  input  edc_pkg::cmd_t               cmd_i,
  output edc_pkg::status_t            status_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [edc_pkg::MONTH_W-1:0] month_o,
  output logic [edc_pkg::DOM_W-1:0]   day_of_month_o,
  output logic [edc_pkg::YEAR_W-1:0]  year_o,
  output logic                        valid_res_o
);

  logic [edc_pkg::DAY_W-1:0]   rem_q, rem_d;
  logic [edc_pkg::YEAR_W-1:0]  year_q, year_d;
  logic [edc_pkg::MONTH_W-1:0] month_q, month_d;
  logic                        ok_q, ok_d;
  logic                        out_valid_q, out_valid_d;

  logic [edc_pkg::MONTH_W-1:0] month_res_q;
  logic [edc_pkg::DOM_W-1:0]   dom_res_q;
  logic [edc_pkg::YEAR_W-1:0]  year_res_q;
  logic                        valid_res_q;

  logic                        leap;
  logic [edc_pkg::YLEN_W-1:0]  ylen;
  logic [edc_pkg::DOM_W-1:0]   mlen;
  logic [edc_pkg::DAY_W-1:0]   ylen_ext;
  logic [edc_pkg::DAY_W-1:0]   mlen_ext;

  // every fourth year is a leap year over the whole allowed range
  assign leap     = (year_q[1:0] == 2'b00);
  assign ylen     = leap ? 9'd366 : 9'd365;
  assign mlen     = edc_pkg::month_len(month_q, leap);
  assign ylen_ext = edc_pkg::DAY_W'(ylen);
  assign mlen_ext = edc_pkg::DAY_W'(mlen);

  always_comb begin
    rem_d   = rem_q;
    year_d  = year_q;
    month_d = month_q;
    ok_d    = ok_q;
    if (cmd_i.load) begin
      rem_d   = day_count_i - edc_pkg::DAY_W'(1);
      year_d  = edc_pkg::YEAR_FIRST;
      month_d = '0;
      ok_d    = (day_count_i != '0) && edc_pkg::SPAN_OK;
    end
    if (cmd_i.year_step) begin
      rem_d  = rem_q - ylen_ext;
      year_d = year_q + edc_pkg::YEAR_W'(1);
    end
    if (cmd_i.month_step) begin
      rem_d   = rem_q - mlen_ext;
      month_d = month_q + edc_pkg::MONTH_W'(1);
    end
    if (cmd_i.mark_bad) begin
      ok_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else begin
      ok_q <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    year_q  <= year_d;
    month_q <= month_d;
  end

  always_comb begin
    status_o.res_ok     = ok_q;
    status_o.year_fits  = (rem_q < ylen_ext);
    status_o.year_last  = (year_q == edc_pkg::YEAR_LAST);
    status_o.month_fits = (rem_q < mlen_ext);
    status_o.month_last = (month_q == edc_pkg::MONTH_DEC);
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  // output register: hold until taken, load a new date when free
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      valid_res_q <= ok_q;
      month_res_q <= ok_q ? month_q + edc_pkg::MONTH_W'(1) : '0;
      dom_res_q   <= ok_q ? rem_q[edc_pkg::DOM_W-1:0] + edc_pkg::DOM_W'(1) : '0;
      year_res_q  <= ok_q ? year_q : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign month_o        = month_res_q;
  assign day_of_month_o = dom_res_q;
  assign year_o         = year_res_q;
  assign valid_res_o    = valid_res_q;

  `EDC_ASSERT(a_month_step_in_range, clk_i, rst_ni,
              !cmd_i.month_step || (month_q != edc_pkg::MONTH_DEC))
  `EDC_ASSERT(a_year_step_in_span, clk_i, rst_ni,
              !cmd_i.year_step || (year_q != edc_pkg::YEAR_LAST))
  `EDC_ASSERT_NEXT(a_valid_date_sane, clk_i, rst_ni, cmd_i.out_load && ok_q,
                   (month_res_q != '0) && (month_res_q <= 4'd12) && (dom_res_q != '0))

endmodule
